// File: design/mrdt_pkg.sv
`default_nettype none
package mrdt_pkg;

	localparam logic CMD_TRACK = 1'b0;
	localparam logic CMD_CLEAR = 1'b1;

	typedef struct packed {
		logic        cmd;
		logic [3:0]  region_kind;
		logic [31:0] region_addr;
		logic [31:0] region_size;
		logic [63:0] content_hash_low;
		logic [63:0] content_hash_high;
	} req_item_t;

	typedef struct packed {
		logic        emit;
		logic [3:0]  emit_kind;
		logic [31:0] emit_addr;
		logic [31:0] emit_size;
		logic        table_full;
	} rsp_item_t;

	// One recorded range; stop_addr is start plus size, compared inclusively, and 33 bits wide so it never wraps.
	typedef struct packed {
		logic [31:0] start_addr;
		logic [32:0] stop_addr;
		logic [63:0] hash_high;
		logic [63:0] hash_low;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	// Result of comparing one stored entry against the pending request.
	typedef struct packed {
		logic hit;     // request start falls in [start, stop]
		logic covered; // request lies inside and the hash is equal
	} match_t;

	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_SCAN  = 4'b0010,
		ST_WRITE = 4'b0100,
		ST_DONE  = 4'b1000
	} state_t;

endpackage
`default_nettype wire

// File: design/memory_range_dedup_tracker_unit.sv
`default_nettype none
// A clear or an item with a zero address or size goes straight from idle to done; any other
// item scans the range table, one RAM read and one compare per cycle through the match unit,
// then writes a rewritten or appended range (none on a covered match or a full table) and
// finishes. The block takes no new item until its result has entered the output register.
// Reset (arst_n low, asynchronous): table empty (fill count zero), sequencer idle, no result.
module memory_range_dedup_tracker_unit
	import mrdt_pkg::*;
#(
	parameter int TABLE_DEPTH = 64
) (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      req_valid,
	output logic           req_stall,
	input  wire req_item_t req,
	output logic           rsp_valid,
	input  wire logic      rsp_stall,
	output rsp_item_t      rsp
);

	localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CW = $clog2(TABLE_DEPTH + 1);
	localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);

	state_t state_q;

	// Pending request, captured at accept.
	req_item_t req_q;
	logic [32:0] req_stop_q;

	// Table bookkeeping: entries fill from index 0, so the fill count doubles as valid bits.
	logic [CW-1:0] count_q;

	// Scan pointers: rd_idx_q is the next read, cmp_idx_q the entry whose data is now out.
	logic [CW-1:0] rd_idx_q;
	logic [AW-1:0] cmp_idx_q;
	logic          pend_q;

	// Decided write-back and result.
	logic [AW-1:0] wr_idx_q;
	entry_t        wr_data_q;
	rsp_item_t     res_q;

	logic   req_acc;
	logic   rsp_free;
	logic   rd_en;
	logic   wr_en;
	entry_t rd_entry;
	match_t cmp;

	assign req_acc  = req_valid && !req_stall;
	assign rsp_free = !rsp_valid || !rsp_stall;
	assign req_stall = (state_q != ST_IDLE);
	assign rd_en    = (state_q == ST_SCAN) && (rd_idx_q < count_q);
	assign wr_en    = (state_q == ST_WRITE);

	mrdt_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (TABLE_DEPTH)
	) u_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_idx_q),
		.wr_data (wr_data_q),
		.rd_en   (rd_en),
		.rd_addr (rd_idx_q[AW-1:0]),
		.rd_data (rd_entry)
	);

	// Shared compare unit: one stored entry per cycle against the pending request.
	mrdt_match u_match (
		.entry         (rd_entry),
		.req_addr      (req_q.region_addr),
		.req_stop      (req_stop_q),
		.req_hash_low  (req_q.content_hash_low),
		.req_hash_high (req_q.content_hash_high),
		.result        (cmp)
	);

	// Payload registers: no reset needed.
	always_ff @(posedge clk) begin
		if (req_acc) begin
			req_q      <= req;
			req_stop_q <= {1'b0, req.region_addr} + {1'b0, req.region_size};
		end
	end

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			count_q   <= '0;
			rd_idx_q  <= '0;
			cmp_idx_q <= '0;
			pend_q    <= 1'b0;
			wr_idx_q  <= '0;
			wr_data_q <= '0;
			res_q     <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (req_acc) begin
						res_q    <= '0;
						rd_idx_q <= '0;
						pend_q   <= 1'b0;
						if (req.cmd == CMD_CLEAR) begin
							// Drop every range: the fill count alone marks validity.
							count_q <= '0;
							state_q <= ST_DONE;
						end else if (req.region_addr == '0 || req.region_size == '0) begin
							state_q <= ST_DONE;
						end else begin
							state_q <= ST_SCAN;
						end
					end
				end
				ST_SCAN: begin
					if (pend_q && cmp.hit) begin
						// First matching range wins; stop the scan here.
						if (cmp.covered) begin
							state_q <= ST_DONE;
						end else begin
							wr_idx_q  <= cmp_idx_q;
							wr_data_q <= '{start_addr: rd_entry.start_addr,
							               stop_addr:  req_stop_q,
							               hash_high:  req_q.content_hash_high,
							               hash_low:   req_q.content_hash_low};
							res_q     <= '{emit: 1'b1, emit_kind: req_q.region_kind,
							               emit_addr: req_q.region_addr,
							               emit_size: req_q.region_size,
							               table_full: 1'b0};
							state_q   <= ST_WRITE;
						end
					end else if (!pend_q && rd_idx_q >= count_q) begin
						// No match over the whole table: append, or flag a full table.
						res_q <= '{emit: 1'b1, emit_kind: req_q.region_kind,
						           emit_addr: req_q.region_addr,
						           emit_size: req_q.region_size,
						           table_full: (count_q >= DEPTH_C)};
						if (count_q < DEPTH_C) begin
							wr_idx_q  <= count_q[AW-1:0];
							wr_data_q <= '{start_addr: req_q.region_addr,
							               stop_addr:  req_stop_q,
							               hash_high:  req_q.content_hash_high,
							               hash_low:   req_q.content_hash_low};
							count_q   <= count_q + CW'(1);
							state_q   <= ST_WRITE;
						end else begin
							state_q <= ST_DONE;
						end
					end else begin
						// Advance: the read issued now is compared next cycle.
						pend_q    <= rd_en;
						cmp_idx_q <= rd_idx_q[AW-1:0];
						if (rd_en) begin
							rd_idx_q <= rd_idx_q + CW'(1);
						end
					end
				end
				ST_WRITE: begin
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					// Hold until the output register is free.
					if (rsp_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Output register: load the result once the previous one has been taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid <= 1'b0;
			rsp       <= '0;
		end else if (rsp_free) begin
			rsp_valid <= (state_q == ST_DONE);
			if (state_q == ST_DONE) begin
				rsp <= res_q;
			end
		end
	end

`ifndef SYNTH
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= DEPTH_C)
		else $error("fill count exceeds table depth");

	a_clear_empties: assert property (@(posedge clk) disable iff (!arst_n)
		(req_acc && req.cmd == CMD_CLEAR) |=> (count_q == '0))
		else $error("clear did not empty the table");

	a_full_emits: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp.table_full) |-> rsp.emit)
		else $error("full table flag without emit");

	a_cmp_in_table: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN && pend_q) |-> ({1'b0, cmp_idx_q} < {1'b0, count_q}))
		else $error("compare of an entry beyond the fill count");

	a_write_in_table: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> ({1'b0, wr_idx_q} < {1'b0, count_q}))
		else $error("write beyond the fill count");
`endif

endmodule
`default_nettype wire

// File: design/mrdt_ram.sv
`default_nettype none
module mrdt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             wr_en,
	input  wire logic [AW-1:0]    wr_addr,
	input  wire logic [WIDTH-1:0] wr_data,
	input  wire logic             rd_en,
	input  wire logic [AW-1:0]    rd_addr,
	output logic      [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule
`default_nettype wire

// File: design/mrdt_match.sv
`default_nettype none
module mrdt_match
	import mrdt_pkg::*;
(
	input  wire entry_t      entry,
	input  wire logic [31:0] req_addr,
	input  wire logic [32:0] req_stop,
	input  wire logic [63:0] req_hash_low,
	input  wire logic [63:0] req_hash_high,
	output match_t           result
);

	logic hash_eq;

	// Compare the request against one entry: range check plus hash equality.
	always_comb begin
		hash_eq = (entry.hash_low == req_hash_low) && (entry.hash_high == req_hash_high);
		result.hit = (req_addr >= entry.start_addr) && ({1'b0, req_addr} <= entry.stop_addr);
		result.covered = result.hit && (req_stop <= entry.stop_addr) && hash_eq;
	end

endmodule
`default_nettype wire

// File: test/tb_memory_range_dedup_tracker_unit.sv
`default_nettype none
module tb_memory_range_dedup_tracker_unit;
	import mrdt_pkg::*;

	localparam int TABLE_DEPTH = 64;
	localparam int RANDOM_ITEMS = 1400;
	localparam int RECENT_MAX = 16;
	localparam int HOLD_CYCLES = 300;

	// Expected-result tracker: keeps its own copy of the range table, works out the
	// result each accepted item causes and compares results in arrival order.
	class dedup_checker;
		localparam int DEPTH = TABLE_DEPTH;
		bit          slot_used[DEPTH];
		logic [31:0] slot_start[DEPTH];
		logic [32:0] slot_stop[DEPTH];
		logic [63:0] slot_hlo[DEPTH];
		logic [63:0] slot_hhi[DEPTH];
		int unsigned fill;
		rsp_item_t   pending_rsps[$];
		int unsigned errors;

		function new();
			foreach (slot_used[i]) slot_used[i] = 1'b0;
			fill = 0;
			errors = 0;
		endfunction

		function int unsigned pending();
			return pending_rsps.size();
		endfunction

		function void note_request(req_item_t r);
			rsp_item_t   x;
			logic [32:0] stop;
			bit          hit;
			bit          send;
			x = '0;
			hit = 1'b0;
			send = 1'b0;
			if (r.cmd == CMD_CLEAR) begin
				foreach (slot_used[i]) slot_used[i] = 1'b0;
				fill = 0;
			end else if (r.region_addr != 32'h0 && r.region_size != 32'h0) begin
				stop = {1'b0, r.region_addr} + {1'b0, r.region_size};
				for (int i = 0; i < DEPTH; i++) begin
					if (!hit && slot_used[i] && r.region_addr >= slot_start[i] &&
					    {1'b0, r.region_addr} <= slot_stop[i]) begin
						hit = 1'b1;
						if (!(stop <= slot_stop[i] && r.content_hash_low == slot_hlo[i] &&
						      r.content_hash_high == slot_hhi[i])) begin
							slot_stop[i] = stop;
							slot_hlo[i] = r.content_hash_low;
							slot_hhi[i] = r.content_hash_high;
							send = 1'b1;
						end
					end
				end
				if (!hit) begin
					send = 1'b1;
					if (fill < DEPTH) begin
						slot_used[fill] = 1'b1;
						slot_start[fill] = r.region_addr;
						slot_stop[fill] = stop;
						slot_hlo[fill] = r.content_hash_low;
						slot_hhi[fill] = r.content_hash_high;
						fill++;
					end else begin
						x.table_full = 1'b1;
					end
				end
				if (send) begin
					x.emit = 1'b1;
					x.emit_kind = r.region_kind;
					x.emit_addr = r.region_addr;
					x.emit_size = r.region_size;
				end
			end
			pending_rsps.push_back(x);
		endfunction

		function void check_field(string name, logic [63:0] want, logic [63:0] got);
			if (want !== got) begin
				$error("%s: expected %0h, actual %0h", name, want, got);
				errors++;
			end
		endfunction

		function void check_result(rsp_item_t got);
			rsp_item_t want;
			if (pending_rsps.size() == 0) begin
				$error("result with no item outstanding: %0h", got);
				errors++;
				return;
			end
			want = pending_rsps.pop_front();
			check_field("emit", want.emit, got.emit);
			check_field("emit_kind", want.emit_kind, got.emit_kind);
			check_field("emit_addr", want.emit_addr, got.emit_addr);
			check_field("emit_size", want.emit_size, got.emit_size);
			check_field("table_full", want.table_full, got.table_full);
		endfunction
	endclass

	typedef struct {
		logic [31:0] addr;
		logic [31:0] size;
		logic [63:0] hlo;
		logic [63:0] hhi;
	} region_t;

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      req_valid = 1'b0;
	req_item_t req = '0;
	logic      req_stall;
	logic      rsp_valid;
	logic      rsp_stall = 1'b0;
	rsp_item_t rsp;

	dedup_checker board;
	region_t      recent[$];
	bit           quiet = 1'b0;  // no idling on either side while set
	bit           hold_go = 1'b0; // ask the receiver for its long hold-off

	memory_range_dedup_tracker_unit #(.TABLE_DEPTH(TABLE_DEPTH)) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic req_item_t track_item(logic [3:0] kind, logic [31:0] addr,
	                                         logic [31:0] size, logic [63:0] hlo,
	                                         logic [63:0] hhi);
		req_item_t r;
		r.cmd = CMD_TRACK;
		r.region_kind = kind;
		r.region_addr = addr;
		r.region_size = size;
		r.content_hash_low = hlo;
		r.content_hash_high = hhi;
		return r;
	endfunction

	// Clear ignores the payload; fill it with noise anyway.
	function automatic req_item_t clear_item();
		req_item_t r;
		r = track_item(4'($urandom_range(0, 11)), $urandom, $urandom,
		               {$urandom, $urandom}, {$urandom, $urandom});
		r.cmd = CMD_CLEAR;
		return r;
	endfunction

	// Build one random item. Items not fresh revisit a recently tracked region (exact repeat,
	// sub-range, new hash, growth, start at the inclusive end) so the dedup path is hit;
	// fresh_pct sets how many open new ranges instead.
	function automatic req_item_t make_item(int unsigned fresh_pct);
		req_item_t   r;
		region_t     base;
		region_t     seen;
		int unsigned roll;
		logic [31:0] off;
		roll = $urandom_range(0, 99);
		r = track_item(4'($urandom_range(0, 11)), 32'h0, 32'h0,
		               {$urandom, $urandom}, {$urandom, $urandom});
		if (roll < 1)
			return clear_item();
		if (roll < 4) begin
			// zero address or zero size: leave one of them at zero
			if ($urandom_range(0, 1))
				r.region_size = $urandom;
			else
				r.region_addr = $urandom;
			return r;
		end
		if (recent.size() == 0 || roll >= 100 - fresh_pct) begin
			r.region_addr = $urandom;
			r.region_size = ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(1, 4096);
		end else begin
			base = recent[$urandom_range(0, recent.size() - 1)];
			r.region_addr = base.addr;
			r.region_size = base.size;
			r.content_hash_low = base.hlo;
			r.content_hash_high = base.hhi;
			case ($urandom_range(0, 5))
				0, 1: ;
				2: begin
					off = (base.size > 1) ? $urandom_range(0, base.size - 1) : 32'h0;
					r.region_addr = base.addr + off;
					r.region_size = $urandom_range(1, base.size - off);
				end
				3: begin
					if ($urandom_range(0, 1))
						r.content_hash_low = {$urandom, $urandom};
					else
						r.content_hash_high = {$urandom, $urandom};
				end
				4: begin
					r.region_addr = base.addr + base.size;
					r.region_size = $urandom_range(1, 4096);
				end
				default: r.region_size = base.size + $urandom_range(1, 256);
			endcase
		end
		if (r.region_addr != 32'h0 && r.region_size != 32'h0) begin
			seen.addr = r.region_addr;
			seen.size = r.region_size;
			seen.hlo = r.content_hash_low;
			seen.hhi = r.content_hash_high;
			recent.push_back(seen);
			if (recent.size() > RECENT_MAX)
				void'(recent.pop_front());
		end
		return r;
	endfunction

	// Offer one item from a rising edge and return at the edge that accepts it.
	// Stall is sampled at the falling edge, where every signal has settled.
	task automatic send_item(req_item_t r);
		while (!quiet && $urandom_range(0, 99) < 6) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid <= 1'b1;
		req <= r;
		@(negedge clk);
		while (req_stall)
			@(negedge clk);
		@(posedge clk);
		board.note_request(r);
	endtask

	// Drop valid and hold until every expected result has been taken.
	task automatic drain();
		req_valid <= 1'b0;
		@(posedge clk);
		while (board.pending() != 0)
			@(posedge clk);
	endtask

	// Stimulus
	initial begin
		logic [63:0]  h1;
		logic [63:0]  h2;
		int unsigned  sent;
		int unsigned  ep_len;
		int unsigned  fresh_pct;
		bit           first_ep;
		board = new();
		h1 = {$urandom, $urandom};
		h2 = {$urandom, $urandom};
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: new range, exact repeat, covered sub-range, new hash, start at the
		// inclusive end, zero address, zero size, top of the address space (end past
		// 32 bits), start below a range, clear, retrack after clear.
		send_item(track_item(4'd0, 32'h0000_1000, 32'h0000_0100, h1, h2));
		send_item(track_item(4'd1, 32'h0000_1000, 32'h0000_0100, h1, h2));
		send_item(track_item(4'd2, 32'h0000_1010, 32'h0000_0010, h1, h2));
		send_item(track_item(4'd3, 32'h0000_1000, 32'h0000_0100, h2, h2));
		send_item(track_item(4'd4, 32'h0000_1100, 32'h0000_0020, h2, h2));
		send_item(track_item(4'd5, 32'h0000_1100, 32'h0000_0020, h2, h2));
		send_item(track_item(4'd6, 32'h0000_0000, 32'h0000_0010, h1, h1));
		send_item(track_item(4'd7, 32'h0000_2000, 32'h0000_0000, h1, h1));
		send_item(track_item(4'd11, 32'hFFFF_FFFF, 32'hFFFF_FFFF, '1, '1));
		send_item(track_item(4'd11, 32'hFFFF_FFFF, 32'hFFFF_FFFF, '1, '1));
		send_item(track_item(4'd0, 32'hFFFF_FFFF, 32'h0000_0001, '1, '1));
		send_item(track_item(4'd8, 32'h8000_0000, 32'h0000_0001, '0, '0));
		send_item(track_item(4'd9, 32'h0000_0FFF, 32'h0000_0001, h1, h2));
		send_item(track_item(4'd10, 32'h0000_1000, 32'h0000_0120, h2, h1));
		send_item(clear_item());
		send_item(track_item(4'd0, 32'h0000_1000, 32'h0000_0100, h1, h2));
		send_item(track_item(4'd0, 32'h0000_1000, 32'h0000_0100, h1, h2));
		send_item(track_item(4'd15, '1, '1, '1, '1) | {CMD_CLEAR, {196{1'b0}}});
		send_item(track_item(4'd3, 32'h0000_1000, 32'h0000_0100, h1, h2));

		// Random episodes, each opened by a clear. The first one opens many ranges so
		// the table fills and overflows early.
		sent = 0;
		first_ep = 1'b1;
		while (sent < RANDOM_ITEMS) begin
			ep_len = first_ep ? 140 : $urandom_range(10, 150);
			fresh_pct = first_ep ? 80 : ($urandom_range(0, 1) ? 70 : 20);
			first_ep = 1'b0;
			send_item(clear_item());
			for (int k = 0; k < ep_len && sent < RANDOM_ITEMS; k++) begin
				send_item(make_item(fresh_pct));
				sent++;
				// let the receiver hold off while items keep coming
				if (sent == 400)
					hold_go = 1'b1;
				// pause until the block has returned everything
				if (sent == 700)
					drain();
				quiet = (sent >= 900 && sent < 1100);
			end
		end

		// Wait for the last results, then let the longest scan time pass.
		drain();
		repeat (TABLE_DEPTH + 10) @(posedge clk);
		if (board.errors == 0)
			$display("memory_range_dedup_tracker_unit test passed");
		else
			$display("memory_range_dedup_tracker_unit test failed");
		$finish;
	end

	// Receiver: sample at the falling edge, take the item at the next rising edge,
	// then pick the stall for the following cycle.
	initial begin
		bit          take;
		rsp_item_t   got;
		int unsigned hold_left;
		bit          hold_done;
		hold_left = 0;
		hold_done = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(negedge clk);
			take = (rsp_valid === 1'b1) && !rsp_stall;
			got = rsp;
			@(posedge clk);
			if (take)
				board.check_result(got);
			if (hold_go && !hold_done) begin
				hold_done = 1'b1;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left != 0) begin
				hold_left--;
				rsp_stall <= 1'b1;
			end else if (quiet) begin
				rsp_stall <= 1'b0;
			end else begin
				rsp_stall <= ($urandom_range(0, 99) < 6);
			end
		end
	end

	// Watchdog
	initial begin
		#20000000;
		$display("memory_range_dedup_tracker_unit test failed");
		$finish;
	end

endmodule
`default_nettype wire
